### design/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg: shared constants for the interval set tracker
// Table depth, coordinate width and action codes.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int MaxIntervals = 64;
  localparam int CoordWidth   = 32;
  localparam int IdxWidth     = $clog2(MaxIntervals);
  localparam int CntWidth     = $clog2(MaxIntervals + 1);
  localparam int NeedWidth    = $clog2(2 * MaxIntervals + 2);

  localparam logic [1:0] ActAdd    = 2'd0;
  localparam logic [1:0] ActRemove = 2'd1;
  localparam logic [1:0] ActQuery  = 2'd2;
  localparam logic [1:0] ActUnused = 2'd3;

  typedef logic [CoordWidth-1:0] coord_t;

endpackage

### design/interval_set_tracker.sv
// ----------------------------------------------------------------------------
// interval_set_tracker: sorted table of disjoint half-open intervals
// Add, remove and query of [lo, hi) against a stored interval table.
// ----------------------------------------------------------------------------
// Each request is handled alone. A query scans the table once, one entry a
// cycle. Add and remove first scan the table to count the entries the
// result needs (overflow check), then rewrite it in a second pass, reading
// one old entry a cycle from the live table, except while the second entry
// of a split (or an old one behind the newly placed interval) is written,
// and writing the result into the other of two banks. The pace of both
// passes is set by the single read and write port of each bank and the one
// shared compare unit. Swapping banks commits the new table at once; a
// rejected request simply leaves the active bank as it is.
// One result per request, held in an output register until taken; the next
// request is taken only once that result has gone, or in the cycle it goes.
// Empty or inverted intervals and the unused action code give covered 0 and
// status 0 with no change. The table needs no clearing after reset.
module interval_set_tracker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              action_i,
  input  ist_pkg::coord_t         lo_bound_i,
  input  ist_pkg::coord_t         hi_bound_i,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    covered_o,
  output logic                    status_o
);
  import ist_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1; // query or count pass
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StBuild = 3'd3; // rewrite pass
  localparam logic [2:0] StTail  = 3'd4; // place the pending merged interval
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [1:0]          act_q;
  coord_t              lo_q, hi_q;
  logic [CntWidth-1:0] count_q;
  logic                bank_q;
  logic [CntWidth-1:0] rd_cnt_q;   // entries issued for reading
  logic                rd_vld_q;   // read data valid this cycle
  logic [NeedWidth-1:0] need_q;
  logic [CntWidth-1:0] wr_cnt_q;
  logic                placed_q;
  logic                hit_q;
  logic                out_valid_q, cov_q, stat_q;
  logic                wr2_q;      // second of two entries produced together goes out now

  // two banks, read data registered
  coord_t mem_s0 [MaxIntervals];
  coord_t mem_e0 [MaxIntervals];
  coord_t mem_s1 [MaxIntervals];
  coord_t mem_e1 [MaxIntervals];
  coord_t rs0_q, re0_q, rs1_q, re1_q;
  coord_t ent_s, ent_e;

  logic                rd_en;
  logic [IdxWidth-1:0] rd_addr;
  logic [1:0]          wr_num;     // entries produced this cycle (0..2)
  coord_t              w0s, w0e, w1s, w1e;
  coord_t              w2s_q, w2e_q;
  logic                wr_en;
  logic [IdxWidth-1:0] wr_addr;
  coord_t              wr_s, wr_e;

  assign ent_s = bank_q ? rs1_q : rs0_q;
  assign ent_e = bank_q ? re1_q : re0_q;
  assign rd_addr = rd_cnt_q[IdxWidth-1:0];
  // reading pauses while the second of two entries produced together is written
  assign rd_en = (state_q == StScan || state_q == StBuild) && (rd_cnt_q < count_q) &&
                 !wr2_q;

  logic take_in;
  assign in_stall  = (state_q != StIdle) || (out_valid_q && out_stall);
  assign take_in   = in_valid && !in_stall;
  assign out_valid = out_valid_q;
  assign covered_o = cov_q;
  assign status_o  = stat_q;

  // per-entry classification, shared by both passes
  logic ov_add, below_add, above_add, ov_rem, cut_l, cut_r;
  assign ov_add    = (ent_s <= hi_q) && (ent_e >= lo_q);
  assign below_add = ent_e < lo_q;
  assign above_add = ent_s > hi_q;
  assign ov_rem    = !((ent_e <= lo_q) || (ent_s >= hi_q));
  assign cut_l     = ent_s < lo_q;
  assign cut_r     = ent_e > hi_q;

  logic scan_last, build_last;
  assign scan_last  = !rd_vld_q && (rd_cnt_q >= count_q);

  logic overflow, reject;
  assign overflow = (need_q > NeedWidth'(MaxIntervals));
  assign reject   = (act_q == ActAdd && need_q + NeedWidth'(1) > NeedWidth'(MaxIntervals)) ||
                    (act_q == ActRemove && overflow);

  always_comb begin
    state_d = state_q;
    wr_num  = 2'd0;
    w0s = ent_s; w0e = ent_e; w1s = ent_s; w1e = ent_e;
    build_last = 1'b0;
    case (state_q)
      StIdle: begin
        // empty interval or unused code: no table work
        if (take_in) begin
          state_d = (!(lo_bound_i < hi_bound_i) || action_i == ActUnused) ? StDone : StScan;
        end
      end
      StScan:  if (scan_last) state_d = (act_q == ActQuery) ? StDone : StCheck;
      StCheck: state_d = reject ? StIdle : StBuild;
      StBuild: begin
        if (rd_vld_q && !wr2_q) begin
          if (act_q == ActAdd) begin
            if (below_add) begin
              wr_num = 2'd1;
            end else if (above_add) begin
              if (!placed_q) begin
                wr_num = 2'd2; w0s = lo_q; w0e = hi_q;
              end else begin
                wr_num = 2'd1;
              end
            end
          end else begin
            if (!ov_rem) begin
              wr_num = 2'd1;
            end else begin
              if (cut_l && cut_r) begin
                wr_num = 2'd2; w0e = lo_q; w1s = hi_q;
              end else if (cut_l) begin
                wr_num = 2'd1; w0e = lo_q;
              end else if (cut_r) begin
                wr_num = 2'd1; w0s = hi_q;
              end
            end
          end
        end
        build_last = !rd_vld_q && !wr2_q && (rd_cnt_q >= count_q);
        if (build_last) state_d = StTail;
      end
      StTail: begin
        if (act_q == ActAdd && !placed_q) begin
          wr_num = 2'd1; w0s = lo_q; w0e = hi_q;
        end
        state_d = StDone;
      end
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // one write a cycle: the first entry now, the second of a pair next cycle
  assign wr_en   = (wr_num != 2'd0) || wr2_q;
  assign wr_addr = wr_cnt_q[IdxWidth-1:0];
  assign wr_s    = wr2_q ? w2s_q : w0s;
  assign wr_e    = wr2_q ? w2e_q : w0e;

  always_ff @(posedge clk_i) begin
    w2s_q <= w1s; w2e_q <= w1e;
  end

  // memory: read from active bank, write into the other
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rs0_q <= mem_s0[rd_addr]; re0_q <= mem_e0[rd_addr];
      rs1_q <= mem_s1[rd_addr]; re1_q <= mem_e1[rd_addr];
    end
    if (wr_en) begin
      if (bank_q) begin
        mem_s0[wr_addr] <= wr_s; mem_e0[wr_addr] <= wr_e;
      end else begin
        mem_s1[wr_addr] <= wr_s; mem_e1[wr_addr] <= wr_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; count_q <= '0; bank_q <= 1'b0; rd_cnt_q <= '0;
      rd_vld_q <= 1'b0; need_q <= '0; wr_cnt_q <= '0; placed_q <= 1'b0;
      hit_q <= 1'b0; out_valid_q <= 1'b0; cov_q <= 1'b0; stat_q <= 1'b0;
      act_q <= ActQuery; lo_q <= '0; hi_q <= '0; wr2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr2_q   <= (wr_num == 2'd2);
      if (state_q == StDone || (state_q == StCheck && reject)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
      if (!wr2_q) rd_vld_q <= rd_en;
      if (rd_en) rd_cnt_q <= rd_cnt_q + CntWidth'(1);
      case (state_q)
        StIdle: if (take_in) begin
          lo_q <= lo_bound_i; hi_q <= hi_bound_i; rd_cnt_q <= '0;
          need_q <= '0; hit_q <= 1'b0; placed_q <= 1'b0; wr_cnt_q <= '0;
          act_q <= (lo_bound_i < hi_bound_i) ? action_i : ActUnused;
        end
        StScan: if (rd_vld_q) begin
          if (act_q == ActQuery) begin
            if (ent_s <= lo_q && ent_e >= hi_q) hit_q <= 1'b1;
          end else if (act_q == ActAdd) begin
            if (!ov_add) need_q <= need_q + NeedWidth'(1);
          end else begin
            need_q <= need_q + NeedWidth'(!ov_rem ? 2'd1 : {1'b0, cut_l} + {1'b0, cut_r});
          end
        end
        StCheck: begin
          rd_cnt_q <= '0;
          if (reject) begin
            stat_q <= 1'b1; cov_q <= 1'b0;
          end
        end
        StBuild: begin
          if (wr_en) wr_cnt_q <= wr_cnt_q + CntWidth'(1);
          if (rd_vld_q && !wr2_q && act_q == ActAdd) begin
            if (above_add) placed_q <= 1'b1;
            else if (!below_add) begin
              if (cut_l) lo_q <= ent_s;
              if (cut_r) hi_q <= ent_e;
            end
          end
        end
        StTail: if (wr_en) wr_cnt_q <= wr_cnt_q + CntWidth'(1);
        StDone: begin
          stat_q <= 1'b0;
          cov_q <= (act_q == ActQuery) && hit_q;
          if (act_q == ActAdd || act_q == ActRemove) begin
            bank_q <= !bank_q; count_q <= wr_cnt_q;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntWidth'(MaxIntervals)) else $error("table count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall) else $error("request taken while busy");
  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stat_q && !$past(out_valid_q)) |-> $stable(bank_q))
    else $error("rejected request changed the table");
`endif
endmodule

### bench/interval_set_tracker_tb.sv
// ----------------------------------------------------------------------------
// interval_set_tracker_tb: self-checking bench for the interval set tracker
// Random and directed add/remove/query requests against an own model of the
// interval table; results checked in order, field by field.
// ----------------------------------------------------------------------------
module interval_set_tracker_tb;
  import ist_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int NumRandom     = 1320;

  typedef struct packed {
    logic [1:0] action;
    coord_t     lo;
    coord_t     hi;
  } request_t;

  typedef struct packed {
    logic covered;
    logic status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action_i = ActQuery;
  coord_t lo_bound_i = '0;
  coord_t hi_bound_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic covered_o;
  logic status_o;

  interval_set_tracker u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action_i   (action_i),
    .lo_bound_i (lo_bound_i),
    .hi_bound_i (hi_bound_i),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .covered_o  (covered_o),
    .status_o   (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow of the interval table, kept sorted and disjoint.
  logic [63:0] tbl_lo[$];
  logic [63:0] tbl_hi[$];

  request_t pending_req[$];
  answer_t  expected_ans[$];

  int  mismatches = 0;
  int  n_sent = 0, n_checked = 0, n_full = 0, n_hits = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_send = 1'b0;
  bit  done_stim = 1'b0;

  task automatic queue_req(request_t r);
    pending_req = {pending_req, r};
  endtask

  // Works out the result of one request and updates the shadow table.
  function automatic answer_t apply_request(request_t r);
    logic [63:0] lo, hi;
    logic [63:0] nlo[$], nhi[$];
    answer_t a;
    int merged, need;
    bit placed;
    lo = {32'd0, r.lo};
    hi = {32'd0, r.hi};
    a = '0;
    merged = 0;
    need = 0;
    placed = 1'b0;
    if (lo >= hi) return a;
    case (r.action)
      ActAdd: begin
        foreach (tbl_lo[i]) if (tbl_lo[i] <= hi && tbl_hi[i] >= lo) merged++;
        if (tbl_lo.size() - merged + 1 > MaxIntervals) begin
          a.status = 1'b1;
          return a;
        end
        foreach (tbl_lo[i]) begin
          if (tbl_hi[i] < lo) begin
            nlo = {nlo, tbl_lo[i]}; nhi = {nhi, tbl_hi[i]};
          end else if (tbl_lo[i] > hi) begin
            if (!placed) begin
              nlo = {nlo, lo}; nhi = {nhi, hi}; placed = 1'b1;
            end
            nlo = {nlo, tbl_lo[i]}; nhi = {nhi, tbl_hi[i]};
          end else begin
            if (tbl_lo[i] < lo) lo = tbl_lo[i];
            if (tbl_hi[i] > hi) hi = tbl_hi[i];
          end
        end
        if (!placed) begin
          nlo = {nlo, lo}; nhi = {nhi, hi};
        end
        tbl_lo = nlo; tbl_hi = nhi;
      end
      ActRemove: begin
        foreach (tbl_lo[i]) begin
          if (tbl_hi[i] <= lo || tbl_lo[i] >= hi) need++;
          else begin
            if (tbl_lo[i] < lo) need++;
            if (tbl_hi[i] > hi) need++;
          end
        end
        if (need > MaxIntervals) begin
          a.status = 1'b1;
          return a;
        end
        foreach (tbl_lo[i]) begin
          if (tbl_hi[i] <= lo || tbl_lo[i] >= hi) begin
            nlo = {nlo, tbl_lo[i]}; nhi = {nhi, tbl_hi[i]};
          end else begin
            if (tbl_lo[i] < lo) begin
              nlo = {nlo, tbl_lo[i]}; nhi = {nhi, lo};
            end
            if (tbl_hi[i] > hi) begin
              nlo = {nlo, hi}; nhi = {nhi, tbl_hi[i]};
            end
          end
        end
        tbl_lo = nlo; tbl_hi = nhi;
      end
      ActQuery: begin
        foreach (tbl_lo[i]) if (tbl_lo[i] <= lo && tbl_hi[i] >= hi) a.covered = 1'b1;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic request_t mk_req(logic [1:0] act, coord_t lo, coord_t hi);
    request_t r;
    r.action = act;
    r.lo = lo;
    r.hi = hi;
    return r;
  endfunction

  // Coordinates mostly in a narrow window so intervals collide often;
  // some requests span the full 32-bit range.
  function automatic request_t rand_req();
    request_t r;
    int unsigned w, base, len;
    w = $urandom_range(0, 99);
    r.action = ($urandom_range(0, 49) == 0) ? ActUnused : 2'($urandom_range(0, 2));
    if (w < 80) begin
      base = $urandom_range(0, 1000);
      len = $urandom_range(1, 12);
      r.lo = base;
      r.hi = base + len;
      if ($urandom_range(0, 30) == 0) r.hi = r.lo - $urandom_range(0, 3);
    end else if (w < 90) begin
      r.lo = $urandom;
      r.hi = $urandom;
    end else begin
      base = $urandom;
      r.lo = base;
      r.hi = (base > 32'hFFFF_FFF0) ? 32'hFFFF_FFFF : base + $urandom_range(1, 15);
    end
    return r;
  endfunction

  // Driver: holds a request until accepted; pauses at random.
  always @(posedge clk_i) begin
    request_t r;
    if (rst_ni) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) n_sent <= n_sent + 1;
        if (pending_req.size() > 0 && !hold_send &&
            (no_idle || $urandom_range(0, 99) >= 28)) begin
          r = pending_req.pop_front();
          expected_ans = {expected_ans, apply_request(r)};
          in_valid   <= 1'b1;
          action_i   <= r.action;
          lo_bound_i <= r.lo;
          hi_bound_i <= r.hi;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expectation.
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_ans.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: covered %0b status %0b", covered_o, status_o);
        end else begin
          e = expected_ans.pop_front();
          n_checked++;
          if (e.status) n_full++;
          if (e.covered) n_hits++;
          if (e.covered !== covered_o || e.status !== status_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected covered %0b status %0b, got %0b %0b",
                       n_checked, e.covered, e.status, covered_o, status_o);
          end
        end
      end
      out_stall <= !no_idle && ($urandom_range(0, 99) < 28);
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no progress");
      $display("interval_set_tracker_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: edges of both bounds, every action, empty and inverted spans.
    queue_req(mk_req(ActQuery, 32'd0, 32'd1));
    queue_req(mk_req(ActAdd, 32'd0, 32'hFFFF_FFFF));
    queue_req(mk_req(ActQuery, 32'd0, 32'hFFFF_FFFF));
    queue_req(mk_req(ActRemove, 32'd10, 32'd20));
    queue_req(mk_req(ActQuery, 32'd5, 32'd15));
    queue_req(mk_req(ActQuery, 32'd20, 32'hFFFF_FFFF));
    queue_req(mk_req(ActAdd, 32'd5, 32'd5));
    queue_req(mk_req(ActRemove, 32'd40, 32'd30));
    queue_req(mk_req(ActQuery, 32'd9, 32'd9));
    queue_req(mk_req(ActUnused, 32'd0, 32'd100));
    queue_req(mk_req(ActAdd, 32'd10, 32'd20));
    queue_req(mk_req(ActRemove, 32'd0, 32'hFFFF_FFFF));
    queue_req(mk_req(ActAdd, 32'd100, 32'd110));
    queue_req(mk_req(ActAdd, 32'd110, 32'd120));
    queue_req(mk_req(ActQuery, 32'd100, 32'd120));
    queue_req(mk_req(ActRemove, 32'hFFFF_FFFE, 32'hFFFF_FFFF));
    // Fill the table to its limit, then overflow on add.
    for (int i = 0; i < MaxIntervals; i++)
      queue_req(mk_req(ActAdd, 32'(1000 + 4 * i), 32'(1002 + 4 * i)));
    queue_req(mk_req(ActAdd, 32'd5000, 32'd5001));
    queue_req(mk_req(ActRemove, 32'd1000, 32'd1001));
    queue_req(mk_req(ActAdd, 32'd1002, 32'd1004));
    queue_req(mk_req(ActQuery, 32'd1000, 32'd1006));
    queue_req(mk_req(ActRemove, 32'd0, 32'hFFFF_FFFF));

    wait (pending_req.size() == 0);
    // Hold the sender until the block has drained completely.
    hold_send = 1'b1;
    wait (expected_ans.size() == 0 && !in_valid);
    hold_send = 1'b0;

    for (int i = 0; i < NumRandom; i++) begin
      queue_req(rand_req());
      if (i == NumRandom / 2) no_idle = 1'b1;
      if (i == NumRandom / 2 + 200) no_idle = 1'b0;
      if (i % 64 == 0) wait (pending_req.size() < 8);
    end
    wait (pending_req.size() == 0 && !in_valid);
    wait (expected_ans.size() == 0);
    repeat (300) @(posedge clk_i);

    $display("ran %0d requests, %0d results checked, %0d overflow rejects, %0d covered queries",
             n_sent, n_checked, n_full, n_hits);
    if (mismatches == 0) $display("interval_set_tracker_tb: done, clean");
    else begin
      $display("%0d mismatches", mismatches);
      $display("interval_set_tracker_tb: done, errors");
    end
    $finish;
  end

endmodule
